[design/second_chance_frame_table_assert.svh]
// Assertion macros for the frame table block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SECOND_CHANCE_FRAME_TABLE_ASSERT_SVH
`define SECOND_CHANCE_FRAME_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
// check with the usual active-low reset gating
`define SCFT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that must also hold while reset is asserted
`define SCFT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCFT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCFT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[design/scft_pkg.sv]
// Shared constants and types of the second-chance frame table.
// Used by scft_engine and second_chance_frame_table; depends on nothing.
package scft_pkg;

  localparam int FRAMES_DEF     = 64;
  localparam int PAGE_BITS_DEF  = 20;
  localparam int OWNER_BITS_DEF = 8;

  localparam int FUNC_W = 2;

  // item function codes
  localparam logic [FUNC_W-1:0] FN_TOUCH = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd2;

  // result control from the engine to the output stage
  typedef struct packed {
    logic vld;      // result held, waiting for the output register
    logic status;   // 1: no matching frame or unknown function
    logic evicted;  // allocate replaced a victim
    logic dirty;    // victim's dirty flag
  } scft_res_ctl_t;

endpackage

[design/scft_engine.sv]
// Sequencer and storage of the frame table: tag and order memories, per-frame bits.
// Depends on scft_pkg and second_chance_frame_table_assert.svh.
`include "second_chance_frame_table_assert.svh"

module scft_engine #(
  parameter int FRAMES     = scft_pkg::FRAMES_DEF,
  parameter int PAGE_BITS  = scft_pkg::PAGE_BITS_DEF,
  parameter int OWNER_BITS = scft_pkg::OWNER_BITS_DEF,
  localparam int IDX_W     = $clog2(FRAMES),
  localparam int CNT_W     = $clog2(FRAMES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [scft_pkg::FUNC_W-1:0] func_i,
  input  logic [OWNER_BITS-1:0]       owner_i,
  input  logic [PAGE_BITS-1:0]        vpage_i,
  input  logic                        written_i,
  input  logic [IDX_W-1:0]            frame_sel_i,
  input  logic [CNT_W-1:0]            lim_i,
  input  logic                        take_i,
  output logic                        busy_o,
  output scft_pkg::scft_res_ctl_t     ctl_o,
  output logic [IDX_W-1:0]            res_idx_o,
  output logic [OWNER_BITS-1:0]       res_owner_o,
  output logic [PAGE_BITS-1:0]        res_page_o
);

  localparam int TAG_W = OWNER_BITS + PAGE_BITS;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_TOUCH  = 4'd1;
  localparam logic [3:0] ST_FIND   = 4'd2;
  localparam logic [3:0] ST_EVICT  = 4'd3;
  localparam logic [3:0] ST_VICRD  = 4'd4;
  localparam logic [3:0] ST_LOOK   = 4'd5;
  localparam logic [3:0] ST_SHIFT  = 4'd6;
  localparam logic [3:0] ST_APPEND = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W:0]   n_q, n_d;
  logic             pv_q, pv_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic [IDX_W-1:0] vf_q, vf_d;
  logic [IDX_W-1:0] vpos_q, vpos_d;

  logic [FRAMES-1:0] used_q, used_d;
  logic [FRAMES-1:0] acc_q, acc_d;
  logic [FRAMES-1:0] dirty_q, dirty_d;
  logic [CNT_W-1:0]  used_cnt_q, used_cnt_d;

  // captured item
  logic [scft_pkg::FUNC_W-1:0] func_q;
  logic [OWNER_BITS-1:0]       owner_q;
  logic [PAGE_BITS-1:0]        vpage_q;
  logic                        written_q;
  logic [IDX_W-1:0]            sel_q;

  // result under construction
  logic                  res_status_q, res_status_d;
  logic                  res_ev_q, res_ev_d;
  logic                  res_dirty_q, res_dirty_d;
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;
  logic [OWNER_BITS-1:0] res_own_q, res_own_d;
  logic [PAGE_BITS-1:0]  res_pg_q, res_pg_d;

  // tag memory: {owner, vpage} per frame
  logic [TAG_W-1:0] tag_mem [FRAMES];
  logic [TAG_W-1:0] tag_rd_q;
  logic             tag_we;
  logic [IDX_W-1:0] tag_waddr, tag_raddr;
  logic [TAG_W-1:0] tag_wdata;

  // allocation order memory: frame indices, oldest at position 0
  logic [IDX_W-1:0] ord_mem [FRAMES];
  logic [IDX_W-1:0] ord_rd_q;
  logic             ord_we;
  logic [IDX_W-1:0] ord_waddr, ord_raddr, ord_wdata;

  logic [TAG_W-1:0] key;
  logic [CNT_W-1:0] nxt;
  logic [CNT_W-1:0] last;
  logic [CNT_W:0]   two_used;
  logic [IDX_W-1:0] cidx;
  logic             sel_hit;

  assign key      = {owner_q, vpage_q};
  assign nxt      = cnt_q + 1'b1;
  assign last     = used_cnt_q - 1'b1;
  assign two_used = {used_cnt_q, 1'b0};
  assign cidx     = cnt_q[IDX_W-1:0];
  assign sel_hit  = (frame_sel_i <= IDX_W'(FRAMES - 1)) && used_q[frame_sel_i];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    n_d          = n_q;
    pv_d         = 1'b0;
    pidx_d       = pidx_q;
    vf_d         = vf_q;
    vpos_d       = vpos_q;
    used_d       = used_q;
    acc_d        = acc_q;
    dirty_d      = dirty_q;
    used_cnt_d   = used_cnt_q;
    res_status_d = res_status_q;
    res_ev_d     = res_ev_q;
    res_dirty_d  = res_dirty_q;
    res_idx_d    = res_idx_q;
    res_own_d    = res_own_q;
    res_pg_d     = res_pg_q;
    tag_we       = 1'b0;
    tag_waddr    = '0;
    tag_wdata    = '0;
    tag_raddr    = '0;
    ord_we       = 1'b0;
    ord_waddr    = '0;
    ord_wdata    = '0;
    ord_raddr    = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_status_d = 1'b0;
          res_ev_d     = 1'b0;
          res_dirty_d  = 1'b0;
          res_idx_d    = '0;
          res_own_d    = '0;
          res_pg_d     = '0;
          cnt_d        = '0;
          n_d          = '0;
          case (func_i)
            scft_pkg::FN_TOUCH: state_d = ST_TOUCH;
            scft_pkg::FN_ALLOC: begin
              if (used_cnt_q < lim_i) begin
                state_d = ST_FIND;
              end else if (used_cnt_q != '0) begin
                state_d = ST_EVICT;
              end else begin
                res_status_d = 1'b1;
                state_d      = ST_OUT;
              end
            end
            scft_pkg::FN_FREE: begin
              if (sel_hit) begin
                state_d = ST_LOOK;
              end else begin
                res_status_d = 1'b1;
                state_d      = ST_OUT;
              end
            end
            default: begin
              res_status_d = 1'b1;
              state_d      = ST_OUT;
            end
          endcase
        end
      end

      // walk all frames, compare each tag in the cycle after its read
      ST_TOUCH: begin
        if (cnt_q < CNT_W'(FRAMES)) begin
          tag_raddr = cidx;
          pv_d      = 1'b1;
          pidx_d    = cidx;
          cnt_d     = nxt;
        end
        if (pv_q) begin
          if (used_q[pidx_q] && tag_rd_q == key) begin
            acc_d[pidx_q] = 1'b1;
            if (written_q) begin
              dirty_d[pidx_q] = 1'b1;
            end
            res_idx_d = pidx_q;
            pv_d      = 1'b0;
            state_d   = ST_OUT;
          end else if (pidx_q == IDX_W'(FRAMES - 1)) begin
            res_status_d = 1'b1;
            pv_d         = 1'b0;
            state_d      = ST_OUT;
          end
        end
      end

      // lowest free frame, one per cycle
      ST_FIND: begin
        if (!used_q[cidx]) begin
          tag_we          = 1'b1;
          tag_waddr       = cidx;
          tag_wdata       = key;
          used_d[cidx]    = 1'b1;
          acc_d[cidx]     = 1'b0;
          dirty_d[cidx]   = 1'b0;
          ord_we          = 1'b1;
          ord_waddr       = used_cnt_q[IDX_W-1:0];
          ord_wdata       = cidx;
          used_cnt_d      = used_cnt_q + 1'b1;
          res_idx_d       = cidx;
          state_d         = ST_OUT;
        end else if (cnt_q == CNT_W'(FRAMES - 1)) begin
          cnt_d = '0;
          n_d   = '0;
          if (used_cnt_q != '0) begin
            state_d = ST_EVICT;
          end else begin
            res_status_d = 1'b1;
            state_d      = ST_OUT;
          end
        end else begin
          cnt_d = nxt;
        end
      end

      // clock hand: read order entry, then test/clear its accessed bit
      ST_EVICT: begin
        if (n_q < two_used) begin
          ord_raddr = cidx;
          pv_d      = 1'b1;
          pidx_d    = cidx;
          cnt_d     = (nxt == used_cnt_q) ? '0 : nxt;
          n_d       = n_q + 1'b1;
        end
        if (pv_q) begin
          if (acc_q[ord_rd_q]) begin
            acc_d[ord_rd_q] = 1'b0;
          end else begin
            vf_d      = ord_rd_q;
            vpos_d    = pidx_q;
            tag_raddr = ord_rd_q;
            pv_d      = 1'b0;
            state_d   = ST_VICRD;
          end
        end else if (n_q == two_used) begin
          res_status_d = 1'b1;
          state_d      = ST_OUT;
        end
      end

      // victim tag is in the read register; remap the frame
      ST_VICRD: begin
        res_ev_d      = 1'b1;
        res_own_d     = tag_rd_q[TAG_W-1 -: OWNER_BITS];
        res_pg_d      = tag_rd_q[PAGE_BITS-1:0];
        res_dirty_d   = dirty_q[vf_q];
        res_idx_d     = vf_q;
        tag_we        = 1'b1;
        tag_waddr     = vf_q;
        tag_wdata     = key;
        acc_d[vf_q]   = 1'b0;
        dirty_d[vf_q] = 1'b0;
        cnt_d         = CNT_W'(vpos_q);
        state_d       = ST_SHIFT;
      end

      // find the order position of the frame being freed
      ST_LOOK: begin
        if (cnt_q < used_cnt_q) begin
          ord_raddr = cidx;
          pv_d      = 1'b1;
          pidx_d    = cidx;
          cnt_d     = nxt;
        end
        if (pv_q && ord_rd_q == sel_q) begin
          vpos_d  = pidx_q;
          cnt_d   = CNT_W'(pidx_q);
          pv_d    = 1'b0;
          state_d = ST_SHIFT;
        end else if (!pv_q && cnt_q >= used_cnt_q) begin
          used_d[sel_q]  = 1'b0;
          acc_d[sel_q]   = 1'b0;
          dirty_d[sel_q] = 1'b0;
          state_d        = ST_OUT;
        end
      end

      // close the gap: order[j] <= order[j+1], one entry per cycle
      ST_SHIFT: begin
        if (nxt < used_cnt_q) begin
          ord_raddr = nxt[IDX_W-1:0];
          pv_d      = 1'b1;
          pidx_d    = cidx;
          cnt_d     = nxt;
        end
        if (pv_q) begin
          ord_we    = 1'b1;
          ord_waddr = pidx_q;
          ord_wdata = ord_rd_q;
        end else if (!(nxt < used_cnt_q)) begin
          state_d = ST_APPEND;
        end
      end

      ST_APPEND: begin
        if (func_q == scft_pkg::FN_ALLOC) begin
          ord_we    = 1'b1;
          ord_waddr = last[IDX_W-1:0];
          ord_wdata = vf_q;
        end else begin
          used_cnt_d     = last;
          used_d[sel_q]  = 1'b0;
          acc_d[sel_q]   = 1'b0;
          dirty_d[sel_q] = 1'b0;
        end
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      n_q          <= '0;
      pv_q         <= 1'b0;
      used_q       <= '0;
      acc_q        <= '0;
      dirty_q      <= '0;
      used_cnt_q   <= '0;
      res_status_q <= 1'b0;
      res_ev_q     <= 1'b0;
      res_dirty_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      n_q          <= n_d;
      pv_q         <= pv_d;
      used_q       <= used_d;
      acc_q        <= acc_d;
      dirty_q      <= dirty_d;
      used_cnt_q   <= used_cnt_d;
      res_status_q <= res_status_d;
      res_ev_q     <= res_ev_d;
      res_dirty_q  <= res_dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q    <= pidx_d;
    vf_q      <= vf_d;
    vpos_q    <= vpos_d;
    res_idx_q <= res_idx_d;
    res_own_q <= res_own_d;
    res_pg_q  <= res_pg_d;
    if (start_i && state_q == ST_IDLE) begin
      func_q    <= func_i;
      owner_q   <= owner_i;
      vpage_q   <= vpage_i;
      written_q <= written_i;
      sel_q     <= frame_sel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    tag_rd_q <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd_q <= ord_mem[ord_raddr];
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign ctl_o.vld     = (state_q == ST_OUT);
  assign ctl_o.status  = res_status_q;
  assign ctl_o.evicted = res_ev_q;
  assign ctl_o.dirty   = res_dirty_q;
  assign res_idx_o     = res_idx_q;
  assign res_owner_o   = res_own_q;
  assign res_page_o    = res_pg_q;

  `SCFT_ASSERT(a_cnt_bound, clk_i, rst_ni, (used_cnt_q <= CNT_W'(FRAMES)),
               "used count above frame count")
  `SCFT_ASSERT(a_cnt_bits, clk_i, rst_ni,
               (state_q == ST_IDLE) |-> (int'(used_cnt_q) == $countones(used_q)),
               "used count disagrees with used bits")
  `SCFT_ASSERT(a_start_busy, clk_i, rst_ni,
               (start_i && state_q == ST_IDLE) |=> (state_q != ST_IDLE),
               "accepted item did not start")
  `SCFT_ASSERT(a_evict_alloc, clk_i, rst_ni,
               (state_q == ST_OUT && res_ev_q) |-> (func_q == scft_pkg::FN_ALLOC && !res_status_q),
               "victim on a non-allocate item")
  `SCFT_ASSERT(a_touch_acc, clk_i, rst_ni,
               (state_q == ST_OUT && func_q == scft_pkg::FN_TOUCH && !res_status_q) |-> acc_q[res_idx_q],
               "touch hit left accessed bit clear")

endmodule

[design/second_chance_frame_table.sv]
// Top level of the second-chance frame table: handshakes, limit register, result register.
// Depends on scft_pkg and scft_engine.

// Physical frame table with second-chance (clock) replacement. One item at a time:
// the input is stalled from acceptance until the item's result moves into the output
// register, and the output register lets the next item start while that result waits.
// Every item gives exactly one result. The tag store and the allocation order are
// memories with one read and one write port, walked one entry per cycle:
//   touch             : linear tag scan, lowest frame wins
//   allocate, free    : free-frame search over used bits
//   allocate, evict   : clock-hand scan (one pass clears every accessed bit, so the
//                       hand stops by the oldest entry on the second pass), victim
//                       tag read, then compaction of the order list
//   free              : order lookup plus compaction
// The result then waits in the engine until the output register takes it.
// Per-frame used, accessed and dirty bits are flops cleared by reset, so there is no
// clearing pass. frame_limit is written through the cfg channel, always ready; the user
// must write it only while idle, which the block does not enforce. The value is
// saturated into 1..FRAMES when written. Reset value is FRAMES.
module second_chance_frame_table #(
  parameter int FRAMES     = scft_pkg::FRAMES_DEF,
  parameter int PAGE_BITS  = scft_pkg::PAGE_BITS_DEF,
  parameter int OWNER_BITS = scft_pkg::OWNER_BITS_DEF,
  localparam int IDX_W     = $clog2(FRAMES),
  localparam int CNT_W     = $clog2(FRAMES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [scft_pkg::FUNC_W-1:0] func_i,
  input  logic [OWNER_BITS-1:0]       owner_i,
  input  logic [PAGE_BITS-1:0]        vpage_i,
  input  logic                        written_i,
  input  logic [IDX_W-1:0]            frame_sel_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic [IDX_W-1:0]            frame_index_o,
  output logic                        evicted_o,
  output logic [OWNER_BITS-1:0]       victim_owner_o,
  output logic [PAGE_BITS-1:0]        victim_page_o,
  output logic                        victim_dirty_o,
  // frame_limit write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CNT_W-1:0]            cfg_data_i
);

  logic                    busy;
  logic                    start;
  logic                    take;
  scft_pkg::scft_res_ctl_t ctl;
  logic [IDX_W-1:0]        res_idx;
  logic [OWNER_BITS-1:0]   res_owner;
  logic [PAGE_BITS-1:0]    res_page;

  // effective limit, kept already saturated
  logic [CNT_W-1:0] lim_q, lim_d;

  logic                  out_valid_q;
  logic                  out_status_q;
  logic [IDX_W-1:0]      out_idx_q;
  logic                  out_ev_q;
  logic [OWNER_BITS-1:0] out_own_q;
  logic [PAGE_BITS-1:0]  out_pg_q;
  logic                  out_dirty_q;

  assign in_stall_o  = busy;
  assign start       = in_valid_i && !busy;
  assign cfg_ready_o = 1'b1;

  // result moves in when the register is empty or drains this cycle
  assign take = !out_valid_q || !out_stall_i;

  always_comb begin
    if (cfg_data_i == '0) begin
      lim_d = CNT_W'(1);
    end else if (cfg_data_i > CNT_W'(FRAMES)) begin
      lim_d = CNT_W'(FRAMES);
    end else begin
      lim_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= CNT_W'(FRAMES);
    end else if (cfg_valid_i) begin
      lim_q <= lim_d;
    end
  end

  scft_engine #(
    .FRAMES     (FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .func_i      (func_i),
    .owner_i     (owner_i),
    .vpage_i     (vpage_i),
    .written_i   (written_i),
    .frame_sel_i (frame_sel_i),
    .lim_i       (lim_q),
    .take_i      (take),
    .busy_o      (busy),
    .ctl_o       (ctl),
    .res_idx_o   (res_idx),
    .res_owner_o (res_owner),
    .res_page_o  (res_page)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.vld && take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.vld && take) begin
      out_status_q <= ctl.status;
      out_idx_q    <= res_idx;
      out_ev_q     <= ctl.evicted;
      out_own_q    <= res_owner;
      out_pg_q     <= res_page;
      out_dirty_q  <= ctl.dirty;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign frame_index_o  = out_idx_q;
  assign evicted_o      = out_ev_q;
  assign victim_owner_o = out_own_q;
  assign victim_page_o  = out_pg_q;
  assign victim_dirty_o = out_dirty_q;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the second-chance frame table.
// Needs scft_pkg and second_chance_frame_table; it keeps its own frame table in step
// with the block and checks every result, field by field, in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES  = scft_pkg::FRAMES_DEF;
  localparam int PAGE_W  = scft_pkg::PAGE_BITS_DEF;
  localparam int OWNER_W = scft_pkg::OWNER_BITS_DEF;
  localparam int IDX_W   = $clog2(FRAMES);
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int FUNC_W  = scft_pkg::FUNC_W;

  localparam logic [FUNC_W-1:0] FN_TOUCH = scft_pkg::FN_TOUCH;
  localparam logic [FUNC_W-1:0] FN_ALLOC = scft_pkg::FN_ALLOC;
  localparam logic [FUNC_W-1:0] FN_FREE  = scft_pkg::FN_FREE;
  // func 3 is not defined by the block; it must answer with status 1
  localparam logic [FUNC_W-1:0] FN_UNKNOWN = 2'd3;

  // worst item: eviction scan over two passes plus order compaction
  localparam int DRAIN_CYCLES   = 3 * FRAMES + 16;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 210;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [OWNER_W-1:0] owner;
    logic [PAGE_W-1:0]  vpage;
    logic               written;
    logic [IDX_W-1:0]   frame_sel;
  } frame_req_t;

  typedef struct packed {
    logic               status;
    logic [IDX_W-1:0]   frame_index;
    logic               evicted;
    logic [OWNER_W-1:0] victim_owner;
    logic [PAGE_W-1:0]  victim_page;
    logic               victim_dirty;
  } frame_rsp_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  func = '0;
  logic [OWNER_W-1:0] owner = '0;
  logic [PAGE_W-1:0]  vpage = '0;
  logic               written = 1'b0;
  logic [IDX_W-1:0]   frame_sel = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               status;
  logic [IDX_W-1:0]   frame_index;
  logic               evicted;
  logic [OWNER_W-1:0] victim_owner;
  logic [PAGE_W-1:0]  victim_page;
  logic               victim_dirty;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data = '0;

  second_chance_frame_table u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .owner_i        (owner),
    .vpage_i        (vpage),
    .written_i      (written),
    .frame_sel_i    (frame_sel),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .frame_index_o  (frame_index),
    .evicted_o      (evicted),
    .victim_owner_o (victim_owner),
    .victim_page_o  (victim_page),
    .victim_dirty_o (victim_dirty),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow frame table, updated as each item is accepted
  // ---------------------------------------------------------------------------
  logic               frm_used     [FRAMES];
  logic               frm_accessed [FRAMES];
  logic               frm_dirty    [FRAMES];
  logic [OWNER_W-1:0] frm_owner    [FRAMES];
  logic [PAGE_W-1:0]  frm_page     [FRAMES];
  logic [IDX_W-1:0]   age_order[$];      // oldest mapping first; size is the use count
  logic [CNT_W-1:0]   limit_reg = CNT_W'(FRAMES);
  frame_rsp_t         pending_rsp[$];    // expected results, oldest first

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_run = 0;
  logic        stall_level = 1'b0;
  logic        gaps_on = 1'b0;
  logic        stall_on = 1'b0;
  frame_rsp_t  got_rsp;
  frame_rsp_t  want_rsp;

  function automatic void map_frame(input int f, input frame_req_t req);
    frm_used[f]     = 1'b1;
    frm_owner[f]    = req.owner;
    frm_page[f]     = req.vpage;
    frm_accessed[f] = 1'b0;
    frm_dirty[f]    = 1'b0;
    age_order.push_back(IDX_W'(f));
  endfunction

  function automatic frame_rsp_t apply_request(input frame_req_t req);
    frame_rsp_t rsp;
    int         lim;
    int         pos;
    int         f;
    bit         done;
    rsp  = '0;
    done = 1'b0;
    case (req.func)
      FN_TOUCH: begin
        // lowest matching frame wins when a mapping is duplicated
        for (int i = 0; i < FRAMES; i++) begin
          if (!done && frm_used[i] && frm_owner[i] == req.owner && frm_page[i] == req.vpage) begin
            frm_accessed[i] = 1'b1;
            if (req.written) frm_dirty[i] = 1'b1;
            rsp.frame_index = IDX_W'(i);
            done = 1'b1;
          end
        end
        if (!done) rsp.status = 1'b1;
      end
      FN_ALLOC: begin
        lim = (limit_reg == 0) ? 1 : (limit_reg > FRAMES) ? FRAMES : int'(limit_reg);
        if (age_order.size() < lim) begin
          for (int i = 0; i < FRAMES; i++) begin
            if (!done && !frm_used[i]) begin
              map_frame(i, req);
              rsp.frame_index = IDX_W'(i);
              done = 1'b1;
            end
          end
        end
        // clock hand: at most two passes over the order, clearing accessed bits
        if (!done && age_order.size() > 0) begin
          for (int n = 0; n < 2 * age_order.size(); n++) begin
            if (!done) begin
              pos = n % age_order.size();
              f   = age_order[pos];
              if (frm_accessed[f]) begin
                frm_accessed[f] = 1'b0;
              end else begin
                rsp.evicted      = 1'b1;
                rsp.victim_owner = frm_owner[f];
                rsp.victim_page  = frm_page[f];
                rsp.victim_dirty = frm_dirty[f];
                age_order.delete(pos);
                map_frame(f, req);
                rsp.frame_index = IDX_W'(f);
                done = 1'b1;
              end
            end
          end
        end
        if (!done) rsp.status = 1'b1;
      end
      FN_FREE: begin
        if (frm_used[req.frame_sel]) begin
          for (int k = 0; k < age_order.size(); k++) begin
            if (!done && age_order[k] == req.frame_sel) begin
              age_order.delete(k);
              done = 1'b1;
            end
          end
          frm_used[req.frame_sel]     = 1'b0;
          frm_accessed[req.frame_sel] = 1'b0;
          frm_dirty[req.frame_sel]    = 1'b0;
        end else begin
          rsp.status = 1'b1;
        end
      end
      default: rsp.status = 1'b1;
    endcase
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Item channel driver: bursts with random gaps, payload held while stalled
  // ---------------------------------------------------------------------------
  task automatic send_request(input frame_req_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    func      <= req.func;
    owner     <= req.owner;
    vpage     <= req.vpage;
    written   <= req.written;
    frame_sel <= req.frame_sel;
    do @(posedge clk); while (in_stall);
    pending_rsp.push_back(apply_request(req));
  endtask

  function automatic frame_req_t frame_request(input logic [FUNC_W-1:0] fn,
                                               input logic [OWNER_W-1:0] own,
                                               input logic [PAGE_W-1:0] pg,
                                               input logic wr,
                                               input logic [IDX_W-1:0] sel);
    frame_req_t req;
    req = '{func: fn, owner: own, vpage: pg, written: wr, frame_sel: sel};
    return req;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // limit is only written with the table idle
  task automatic write_limit(input logic [CNT_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: own stall pattern, in-order field checks
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_run   = $urandom_range(1, 12);
      stall_level = stall_on && ($urandom_range(0, 2) == 0);
    end
    stall_run--;
    out_stall <= stall_level;
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_rsp = {status, frame_index, evicted, victim_owner, victim_page, victim_dirty};
      if (pending_rsp.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got_rsp);
      end else begin
        want_rsp = pending_rsp.pop_front();
        check_field("status",       want_rsp.status,       got_rsp.status);
        check_field("frame_index",  want_rsp.frame_index,  got_rsp.frame_index);
        check_field("evicted",      want_rsp.evicted,      got_rsp.evicted);
        check_field("victim_owner", want_rsp.victim_owner, got_rsp.victim_owner);
        check_field("victim_page",  want_rsp.victim_page,  got_rsp.victim_page);
        check_field("victim_dirty", want_rsp.victim_dirty, got_rsp.victim_dirty);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_rsp.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // every func on an empty and a small table, duplicate mapping, misses
  task automatic test_basic_ops();
    send_request(frame_request(FN_TOUCH, '0, '0, 1'b0, '0));          // miss, empty
    send_request(frame_request(FN_FREE, '0, '0, 1'b0, '0));           // free unused
    send_request(frame_request(FN_UNKNOWN, '1, '1, 1'b1, '1));        // undefined func
    send_request(frame_request(FN_ALLOC, '1, '1, 1'b1, '1));
    send_request(frame_request(FN_ALLOC, '0, '0, 1'b0, '0));
    send_request(frame_request(FN_ALLOC, '1, '1, 1'b0, '0));          // same mapping again
    send_request(frame_request(FN_TOUCH, '1, '1, 1'b1, '0));          // hits lowest frame
    send_request(frame_request(FN_TOUCH, '0, '0, 1'b0, '1));
    send_request(frame_request(FN_FREE, '0, '0, 1'b0, '1));           // top frame unused
    send_request(frame_request(FN_FREE, '1, '1, 1'b1, IDX_W'(1)));
    send_request(frame_request(FN_TOUCH, '0, '0, 1'b1, '0));          // freed, now a miss
    send_request(frame_request(FN_ALLOC, 8'h5a, 20'h5a5a5, 1'b0, '0)); // reuses freed frame
  endtask

  // limit below the number in use: allocate evicts and the count holds
  task automatic test_limit_below_use();
    write_limit(CNT_W'(2));
    send_request(frame_request(FN_ALLOC, 8'h01, 20'h00001, 1'b0, '0));
    send_request(frame_request(FN_TOUCH, 8'h5a, 20'h5a5a5, 1'b1, '0));
    send_request(frame_request(FN_ALLOC, 8'h02, 20'h00002, 1'b0, '0)); // dirty victim
    // all accessed: first pass clears every bit, second pass takes the oldest
    for (int i = 0; i < age_order.size(); i++)
      send_request(frame_request(FN_TOUCH, frm_owner[age_order[i]], frm_page[age_order[i]],
                                 1'b0, '0));
    send_request(frame_request(FN_ALLOC, 8'h03, 20'h00003, 1'b0, '0));
  endtask

  // out-of-range limit values saturate into 1..FRAMES
  task automatic test_limit_saturation();
    write_limit('0);
    send_request(frame_request(FN_ALLOC, 8'h80, 20'h80000, 1'b0, '0));
    while (age_order.size() != 0)
      send_request(frame_request(FN_FREE, '0, '0, 1'b0, age_order[0]));
    send_request(frame_request(FN_ALLOC, 8'h81, 20'h7ffff, 1'b0, '0));
    send_request(frame_request(FN_ALLOC, 8'h82, 20'h00010, 1'b0, '0)); // limit 1: evicts
    write_limit('1);
    send_request(frame_request(FN_ALLOC, 8'h83, 20'h00011, 1'b0, '0));
    write_limit(CNT_W'(FRAMES + 1));
    send_request(frame_request(FN_ALLOC, 8'h84, 20'h00012, 1'b0, '0));
  endtask

  function automatic frame_req_t random_request(input int alloc_w, input int free_w);
    frame_req_t       req;
    int unsigned      roll;
    logic [IDX_W-1:0] pick;
    req.owner     = OWNER_W'($urandom);
    req.vpage     = PAGE_W'($urandom);
    req.written   = 1'($urandom_range(0, 1));
    req.frame_sel = IDX_W'($urandom_range(0, FRAMES - 1));
    req.func      = FN_TOUCH;
    pick = (age_order.size() > 0) ? age_order[$urandom_range(0, age_order.size() - 1)]
                                  : req.frame_sel;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      req.func = FN_UNKNOWN;
    end else if (roll < 3 + alloc_w) begin
      req.func = FN_ALLOC;
      if (frm_used[pick] && $urandom_range(0, 9) == 0) begin
        req.owner = frm_owner[pick];
        req.vpage = frm_page[pick];
      end
    end else if (roll < 3 + alloc_w + free_w) begin
      req.func = FN_FREE;
      if ($urandom_range(0, 3) != 0) req.frame_sel = pick;
    end else if (frm_used[pick] && $urandom_range(0, 4) != 0) begin
      // mostly touches of live mappings so the accessed bits steer eviction
      req.owner = frm_owner[pick];
      req.vpage = frm_page[pick];
    end
    return req;
  endfunction

  // phases at several limits; the first runs with no idling on either side
  task automatic test_random_traffic();
    logic [CNT_W-1:0] lim;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 7:    lim = CNT_W'(FRAMES);
        1:       lim = CNT_W'(1);
        2:       lim = '0;
        3:       lim = '1;
        default: lim = CNT_W'($urandom_range(2, FRAMES - 1));
      endcase
      write_limit(lim);
      gaps_on  = (p != 0) && ($urandom_range(0, 3) != 0);
      stall_on = (p != 0) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (lim == CNT_W'(FRAMES))
          send_request(random_request(55, 7));   // fill the whole table, then evict
        else
          send_request(random_request(35, 15));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < FRAMES; i++) begin
      frm_used[i]     = 1'b0;
      frm_accessed[i] = 1'b0;
      frm_dirty[i]    = 1'b0;
      frm_owner[i]    = '0;
      frm_page[i]     = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_ops();
    test_limit_below_use();
    test_limit_saturation();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/scft_pkg.sv
design/scft_engine.sv
design/second_chance_frame_table.sv
tb/testbench.sv
